### design/stochastic_oscillator_histogram_unit_assert.svh
// Assertion macros for the stochastic oscillator histogram unit.
// Each macro takes a label, an antecedent, a consequent and a message.
// The clock is clk and the reset is rst in every module that uses them.
`ifndef STOCHASTIC_OSCILLATOR_HISTOGRAM_UNIT_ASSERT_SVH
`define STOCHASTIC_OSCILLATOR_HISTOGRAM_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SOHU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SOHU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SOHU_ASSERT_SAME(lbl, ante, cons, msg)
`define SOHU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### design/sho_pkg.sv
`default_nettype none
package sho_pkg;

  localparam int KV_BITS   = 15;
  localparam int HIST_BITS = 16;
  localparam int CFG_BITS  = 6;
  localparam int PCT_MAX   = 25600;

  localparam logic [1:0] REG_K_PERIOD     = 2'd0;
  localparam logic [1:0] REG_D_PERIOD     = 2'd1;
  localparam logic [1:0] REG_SAMPLE_LIMIT = 2'd2;
  localparam logic [1:0] REG_UNUSED       = 2'd3;

  localparam logic [5:0] K_PERIOD_RESET     = 6'd14;
  localparam logic [4:0] D_PERIOD_RESET     = 5'd3;
  localparam logic [5:0] SAMPLE_LIMIT_RESET = 6'd17;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_EVAL   = 8'b0000_0010,
    ST_SCAN   = 8'b0000_0100,
    ST_KSTART = 8'b0000_1000,
    ST_KWAIT  = 8'b0001_0000,
    ST_FSTART = 8'b0010_0000,
    ST_FWAIT  = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage
`default_nettype wire

### design/sho_price_cell.sv
`default_nettype none
module sho_price_cell #(
  parameter int PB = 32
) (
  input  wire logic          clk,
  input  wire logic          push,
  input  wire logic          rot,
  input  wire logic [PB-1:0] push_d,
  input  wire logic [PB-1:0] rot_d,
  output logic      [PB-1:0] q
);

  // A push moves every price one place older; a rotation moves it one place
  // toward the head of the ring.
  always_ff @(posedge clk) begin
    if (push) begin
      q <= push_d;
    end else if (rot) begin
      q <= rot_d;
    end
  end

endmodule
`default_nettype wire

### design/sho_lane.sv
`default_nettype none
module sho_lane #(
  parameter int PB  = 32,
  parameter int IDX = 0,
  parameter int TW  = 6,
  parameter int KW  = 6,
  parameter int CW  = 8
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [TW-1:0] age,
  input  wire logic [KW-1:0] kc,
  input  wire logic [PB-1:0] price,
  output logic      [PB-1:0] cur,
  output logic      [PB-1:0] lo,
  output logic      [PB-1:0] hi
);

  logic [CW-1:0] age_w;
  logic [CW-1:0] first_w;
  logic [CW-1:0] end_w;

  assign age_w   = CW'(age);
  assign first_w = CW'(IDX);
  assign end_w   = CW'(IDX) + CW'(kc);

  // The window of this lane covers ages IDX up to IDX + kc - 1.
  always_ff @(posedge clk) begin
    if (en) begin
      if (age_w == first_w) begin
        cur <= price;
        lo  <= price;
        hi  <= price;
      end else if (age_w > first_w && age_w < end_w) begin
        if (price < lo) lo <= price;
        if (price > hi) hi <= price;
      end
    end
  end

endmodule
`default_nettype wire

### design/sho_div.sv
`default_nettype none
module sho_div #(
  parameter int NW = 47,
  parameter int DW = 32,
  parameter int QW = 15
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NW-1:0]    num,
  input  wire logic [DW-1:0]    den,
  output logic                  done,
  output logic      [QW-1:0]    quo
);

  localparam int RW   = (NW > DW + QW) ? NW : DW + QW;
  localparam int CNTW = $clog2(QW + 1);

  logic [RW-1:0]   rem;
  logic [RW-1:0]   dsh;
  logic [CNTW-1:0] cnt;
  logic            busy;

  // Restoring division, one quotient bit per cycle. The quotient must fit
  // in QW bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(QW);
        rem  <= RW'(num);
        dsh  <= RW'(den) << (QW - 1);
        quo  <= '0;
      end else if (busy) begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          quo <= {quo[QW-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### design/stochastic_oscillator_histogram_unit.sv
`default_nettype none
// Stochastic oscillator histogram (%K minus %D). Each input transaction
// carries one closing price; each one produces exactly one output
// transaction. The prices live in a ring of price cells that the newest
// price enters at the head. When enough history exists the ring makes one
// full rotation while a row of MAX_D_WINDOW lanes collects the low, high
// and newest price of each %K window. A shared restoring divider then
// produces each %K, and one last division forms %K minus %D truncated
// toward zero. A window whose high equals its low skips its division. An
// item without enough history goes from the history check straight to the
// output. The unit works on one item at a time; the output register lets
// the next price be taken while a result still waits. valid_res is 0 (and
// the histogram 0) until k_period + d_period - 1 prices have arrived, with
// both periods clamped, or always when sample_limit is below that count.
// Configuration is written through cfg_we, cfg_index and cfg_data; the
// user must write it only while the unit is idle, which the unit itself
// does not enforce.
`include "stochastic_oscillator_histogram_unit_assert.svh"
module stochastic_oscillator_histogram_unit #(
  parameter int MAX_K_WINDOW = 32,
  parameter int MAX_D_WINDOW = 16,
  parameter int PRICE_BITS   = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [1:0]                           cfg_index,
  input  wire logic [sho_pkg::CFG_BITS-1:0]         cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [31:0]                          close_price,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      valid_res,
  output logic signed [sho_pkg::HIST_BITS-1:0]      histogram
);

  localparam int HIST_DEPTH = MAX_K_WINDOW + MAX_D_WINDOW - 1;
  localparam int PB   = PRICE_BITS;
  localparam int KV   = sho_pkg::KV_BITS;
  localparam int HB   = sho_pkg::HIST_BITS;
  localparam int KW   = $clog2(MAX_K_WINDOW + 1);
  localparam int DW   = $clog2(MAX_D_WINDOW + 1);
  localparam int HW   = $clog2(HIST_DEPTH + 1);
  localparam int TW   = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int LW   = (MAX_D_WINDOW > 1) ? $clog2(MAX_D_WINDOW) : 1;
  localparam int CW   = $clog2(HIST_DEPTH + 64) + 1;
  localparam int SW   = KV + DW;
  localparam int NW   = PB + KV;

  // Configuration registers.
  logic [5:0] k_period;
  logic [4:0] d_period;
  logic [5:0] sample_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_period     <= sho_pkg::K_PERIOD_RESET;
      d_period     <= sho_pkg::D_PERIOD_RESET;
      sample_limit <= sho_pkg::SAMPLE_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sho_pkg::REG_K_PERIOD:     k_period     <= cfg_data;
        sho_pkg::REG_D_PERIOD:     d_period     <= cfg_data[4:0];
        sho_pkg::REG_SAMPLE_LIMIT: sample_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Periods clamped to the range the hardware was built for.
  logic [KW-1:0] kc;
  logic [DW-1:0] dc;

  always_comb begin
    if (k_period == 6'd0) begin
      kc = KW'(1);
    end else if (CW'(k_period) > CW'(MAX_K_WINDOW)) begin
      kc = KW'(MAX_K_WINDOW);
    end else begin
      kc = KW'(k_period);
    end
    if (d_period == 5'd0) begin
      dc = DW'(1);
    end else if (CW'(d_period) > CW'(MAX_D_WINDOW)) begin
      dc = DW'(MAX_D_WINDOW);
    end else begin
      dc = DW'(d_period);
    end
  end

  sho_pkg::state_t state;
  sho_pkg::state_t state_next;

  logic in_acc;
  assign in_stall = (state != sho_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Price ring. Cell 0 holds the newest price, or during a rotation the
  // price whose age equals the scan step.
  logic [PB+31:0] price_ext;
  logic [PB-1:0]  price_new;
  logic [PB-1:0]  ring [HIST_DEPTH];
  logic           rot;

  assign price_ext = {PB'(0), close_price};
  assign price_new = price_ext[PB-1:0];
  assign rot       = (state == sho_pkg::ST_SCAN);

  for (genvar c = 0; c < HIST_DEPTH; c++) begin : g_cell
    logic [PB-1:0] push_src;
    logic [PB-1:0] rot_src;
    if (c == 0) begin : g_head
      assign push_src = price_new;
    end else begin : g_body
      assign push_src = ring[c-1];
    end
    if (c == HIST_DEPTH - 1) begin : g_tail
      assign rot_src = ring[0];
    end else begin : g_mid
      assign rot_src = ring[c+1];
    end
    sho_price_cell #(.PB(PB)) u_cell (
      .clk    (clk),
      .push   (in_acc),
      .rot    (rot),
      .push_d (push_src),
      .rot_d  (rot_src),
      .q      (ring[c])
    );
  end

  // Count of prices seen, saturating at the ring depth.
  logic [HW-1:0] samples_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_seen <= '0;
    end else if (in_acc && samples_seen != HW'(HIST_DEPTH)) begin
      samples_seen <= samples_seen + HW'(1);
    end
  end

  logic [CW-1:0] have;
  logic [CW-1:0] need;
  logic          enough;

  assign have   = (CW'(samples_seen) < CW'(sample_limit)) ? CW'(samples_seen)
                                                          : CW'(sample_limit);
  assign need   = CW'(kc) + CW'(dc) - CW'(1);
  assign enough = (have >= need);

  // Window lanes.
  logic [TW-1:0] age;
  logic [PB-1:0] lane_cur [MAX_D_WINDOW];
  logic [PB-1:0] lane_lo  [MAX_D_WINDOW];
  logic [PB-1:0] lane_hi  [MAX_D_WINDOW];

  for (genvar l = 0; l < MAX_D_WINDOW; l++) begin : g_lane
    sho_lane #(.PB(PB), .IDX(l), .TW(TW), .KW(KW), .CW(CW)) u_lane (
      .clk   (clk),
      .en    (rot),
      .age   (age),
      .kc    (kc),
      .price (ring[0]),
      .cur   (lane_cur[l]),
      .lo    (lane_lo[l]),
      .hi    (lane_hi[l])
    );
  end

  // Selected window and its division operands.
  logic [LW-1:0] win;
  logic [PB-1:0] sel_cur;
  logic [PB-1:0] sel_lo;
  logic [PB-1:0] sel_hi;
  logic [PB-1:0] span_a;
  logic [PB-1:0] span_b;
  logic [NW-1:0] scaled_a;
  logic          flat;
  logic          last_win;

  assign sel_cur  = lane_cur[win];
  assign sel_lo   = lane_lo[win];
  assign sel_hi   = lane_hi[win];
  assign span_a   = sel_cur - sel_lo;
  assign span_b   = sel_hi - sel_lo;
  // 25600 is 2^14 + 2^13 + 2^10.
  assign scaled_a = (NW'(span_a) << 14) + (NW'(span_a) << 13) + (NW'(span_a) << 10);
  assign flat     = !(sel_hi > sel_lo);
  assign last_win = (CW'(win) == CW'(dc) - CW'(1));

  // Final division operands.
  logic [KV-1:0]        kv0;
  logic [SW-1:0]        kv_sum;
  logic signed [SW:0]   fin_num;
  logic [SW-1:0]        fin_mag;
  logic                 fin_neg;

  assign fin_num = $signed({1'b0, SW'(kv0) * SW'(dc)}) - $signed({1'b0, kv_sum});
  assign fin_mag = fin_num[SW] ? SW'(-fin_num) : SW'(fin_num);

  sho_pkg::div_ctl_t div_ctl;
  logic [NW-1:0]     div_num;
  logic [PB-1:0]     div_den;
  logic [KV-1:0]     div_quo;

  assign div_ctl.start = (state == sho_pkg::ST_KSTART && !flat) ||
                         (state == sho_pkg::ST_FSTART);
  assign div_num = (state == sho_pkg::ST_FSTART) ? NW'(fin_mag) : scaled_a;
  assign div_den = (state == sho_pkg::ST_FSTART) ? PB'(dc) : span_b;

  sho_div #(.NW(NW), .DW(PB), .QW(KV)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_ctl.start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_ctl.done),
    .quo   (div_quo)
  );

  // One %K value is ready in this cycle.
  logic          kv_fire;
  logic [KV-1:0] kv_val;

  assign kv_fire = (state == sho_pkg::ST_KSTART && flat) ||
                   (state == sho_pkg::ST_KWAIT && div_ctl.done);
  assign kv_val  = (state == sho_pkg::ST_KWAIT) ? div_quo : '0;

  logic          res_valid;
  logic [HB-1:0] res_hist;
  logic          load_out;

  assign load_out = (state == sho_pkg::ST_OUT) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      sho_pkg::ST_IDLE:   if (in_acc) state_next = sho_pkg::ST_EVAL;
      sho_pkg::ST_EVAL:   state_next = enough ? sho_pkg::ST_SCAN : sho_pkg::ST_OUT;
      sho_pkg::ST_SCAN:   if (age == TW'(HIST_DEPTH - 1)) state_next = sho_pkg::ST_KSTART;
      sho_pkg::ST_KSTART: begin
        if (!flat) begin
          state_next = sho_pkg::ST_KWAIT;
        end else if (last_win) begin
          state_next = sho_pkg::ST_FSTART;
        end
      end
      sho_pkg::ST_KWAIT: begin
        if (div_ctl.done) begin
          state_next = last_win ? sho_pkg::ST_FSTART : sho_pkg::ST_KSTART;
        end
      end
      sho_pkg::ST_FSTART: state_next = sho_pkg::ST_FWAIT;
      sho_pkg::ST_FWAIT:  if (div_ctl.done) state_next = sho_pkg::ST_OUT;
      sho_pkg::ST_OUT:    if (load_out) state_next = sho_pkg::ST_IDLE;
      default:            state_next = sho_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sho_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencing registers and the pending result.
  always_ff @(posedge clk) begin
    if (state == sho_pkg::ST_EVAL) begin
      age       <= '0;
      win       <= '0;
      kv_sum    <= '0;
      res_valid <= 1'b0;
      res_hist  <= '0;
    end
    if (state == sho_pkg::ST_SCAN) begin
      age <= age + TW'(1);
    end
    if (kv_fire) begin
      kv_sum <= kv_sum + SW'(kv_val);
      if (win == '0) kv0 <= kv_val;
      if (!last_win) win <= win + LW'(1);
    end
    if (state == sho_pkg::ST_FSTART) begin
      fin_neg <= fin_num[SW];
    end
    if (state == sho_pkg::ST_FWAIT && div_ctl.done) begin
      res_valid <= 1'b1;
      res_hist  <= fin_neg ? -HB'(div_quo) : HB'(div_quo);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      valid_res <= res_valid;
      histogram <= res_hist;
    end
  end

  // An accepted price always leads to the check of the history count.
  `SOHU_ASSERT_NEXT(a_accept_eval, in_acc, state == sho_pkg::ST_EVAL, "accept did not start an item")
  // The divider only finishes while the sequencer waits for it.
  `SOHU_ASSERT_SAME(a_div_wait, div_ctl.done, state == sho_pkg::ST_KWAIT || state == sho_pkg::ST_FWAIT, "unexpected divider completion")
  // An invalid result carries a zero histogram.
  `SOHU_ASSERT_SAME(a_invalid_zero, out_valid && !valid_res, histogram == '0, "invalid result not zero")
  // A valid result stays within plus or minus 100 percent.
  `SOHU_ASSERT_SAME(a_range, out_valid && valid_res, histogram <= HB'(sho_pkg::PCT_MAX) && histogram >= -HB'(sho_pkg::PCT_MAX), "histogram out of range")

endmodule
`default_nettype wire

### dv/sho_histogram_checker.sv
`default_nettype none
// Watches both channels and the register port, predicts each result from
// the accepted prices and compares it with what the unit delivers.
module sho_histogram_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [sho_pkg::CFG_BITS-1:0]    cfg_data,
  input  wire logic                            in_valid,
  input  wire logic                            in_stall,
  input  wire logic [31:0]                     close_price,
  input  wire logic                            out_valid,
  input  wire logic                            out_stall,
  input  wire logic                            valid_res,
  input  wire logic signed [sho_pkg::HIST_BITS-1:0] histogram,
  output int                                   fails,
  output int                                   pending,
  output int                                   valid_seen
);

  localparam int RING = 47;
  localparam int HB   = sho_pkg::HIST_BITS;

  typedef struct {
    logic                 ok;
    logic signed [HB-1:0] hist;
  } osc_result_t;

  logic [31:0] price_ring [RING];
  int          head;
  int          seen;
  logic [5:0]  k_reg;
  logic [4:0]  d_reg;
  logic [5:0]  limit_reg;
  osc_result_t expected_q [$];

  function automatic logic [31:0] price_back(int age);
    return price_ring[(head + RING - 1 - age) % RING];
  endfunction

  // Computes the %K minus %D result after the newest price is in the ring.
  function automatic osc_result_t next_histogram();
    osc_result_t r;
    int          k, d, need, have;
    longint      sum, k0, num;
    logic [31:0] cur, lo, hi, p;
    longint      kv;
    k = (k_reg < 1) ? 1 : (k_reg > 32) ? 32 : k_reg;
    d = (d_reg < 1) ? 1 : (d_reg > 16) ? 16 : d_reg;
    need = k + d - 1;
    have = (seen < limit_reg) ? seen : limit_reg;
    r.ok = 1'b0;
    r.hist = '0;
    if (have < need) return r;
    sum = 0;
    k0 = 0;
    for (int j = 0; j < d; j++) begin
      cur = price_back(j);
      lo = cur;
      hi = cur;
      for (int a = j; a < j + k; a++) begin
        p = price_back(a);
        if (p < lo) lo = p;
        if (p > hi) hi = p;
      end
      kv = 0;
      if (hi > lo) kv = (longint'(cur - lo) * sho_pkg::PCT_MAX) / longint'(hi - lo);
      if (j == 0) k0 = kv;
      sum += kv;
    end
    // Signed division truncates toward zero, as required.
    num = k0 * d - sum;
    r.ok = 1'b1;
    r.hist = HB'(num / d);
    return r;
  endfunction

  always @(posedge clk) begin
    osc_result_t e;
    if (rst) begin
      head = 0;
      seen = 0;
      k_reg = sho_pkg::K_PERIOD_RESET;
      d_reg = sho_pkg::D_PERIOD_RESET;
      limit_reg = sho_pkg::SAMPLE_LIMIT_RESET;
      expected_q.delete();
      fails = 0;
      valid_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sho_pkg::REG_K_PERIOD:     k_reg = cfg_data;
          sho_pkg::REG_D_PERIOD:     d_reg = cfg_data[4:0];
          sho_pkg::REG_SAMPLE_LIMIT: limit_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        price_ring[head] = close_price;
        head = (head + 1) % RING;
        if (seen < RING) seen++;
        expected_q = {expected_q, next_histogram()};
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected transaction valid_res=%0b histogram=%0d",
                   $time, valid_res, histogram);
          fails++;
        end else begin
          e = expected_q.pop_front();
          if (e.ok !== valid_res) begin
            $display("%0t: valid_res expected %0b actual %0b", $time, e.ok, valid_res);
            fails++;
          end
          if (e.hist !== histogram) begin
            $display("%0t: histogram expected %0d actual %0d", $time, e.hist, histogram);
            fails++;
          end
          if (e.ok) valid_seen++;
        end
      end
    end
    pending = expected_q.size();
  end
endmodule
`default_nettype wire

### dv/tb_stochastic_oscillator_histogram_unit.sv
`default_nettype none
// Top of the testbench. It makes the prices, the register writes and the
// output stalls; the checker beside the unit predicts and compares.
module tb_stochastic_oscillator_histogram_unit;

  localparam int CB = sho_pkg::CFG_BITS;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 cfg_we = 1'b0;
  logic [1:0]                           cfg_index = sho_pkg::REG_K_PERIOD;
  logic [CB-1:0]                        cfg_data = '0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic [31:0]                          close_price = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic                                 valid_res;
  logic signed [sho_pkg::HIST_BITS-1:0] histogram;

  int          fails;
  int          pending;
  int          valid_seen;
  int          gap_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  logic [31:0] last_price = '0;

  always #1 clk = ~clk;

  stochastic_oscillator_histogram_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .close_price(close_price),
    .out_valid(out_valid), .out_stall(out_stall),
    .valid_res(valid_res), .histogram(histogram)
  );

  sho_histogram_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .close_price(close_price),
    .out_valid(out_valid), .out_stall(out_stall),
    .valid_res(valid_res), .histogram(histogram),
    .fails(fails), .pending(pending), .valid_seen(valid_seen)
  );

  // Receiver side. A requested hold keeps the output stalled for a long
  // stretch so that the unit fills up and pushes back on its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req = 0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: a long run of cycles with no transaction on either channel
  // means the unit has hung.
  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 20000) begin
        $display("Timeout after %0d idle cycles, %0d results outstanding",
                 idle_cycles, pending);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Drives one price and returns at the edge where it is taken. The stall
  // is sampled at the falling edge, where it is stable.
  task automatic offer_price(input logic [31:0] p);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    close_price <= p;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    items_sent++;
    last_price = p;
  endtask

  // Lets every outstanding result arrive so that registers can be written.
  task automatic drain_unit();
    in_valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One write, after which the task lowers the write enable again.
  task automatic write_reg(input logic [1:0] idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CB'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_periods(input int k, input int d, input int lim);
    write_reg(sho_pkg::REG_K_PERIOD, k);
    write_reg(sho_pkg::REG_D_PERIOD, d);
    write_reg(sho_pkg::REG_SAMPLE_LIMIT, lim);
  endtask

  // Idling modes rotate: none, sender gaps, receiver stalls, both.
  task automatic pick_idling(input int phase);
    case (phase % 4)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 65; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 65; end
      default: begin gap_pct = 36; stall_pct = 36; end
    endcase
  endtask

  // Prices mix full random words, narrow swings around the last price,
  // flat runs where high equals low, and the two extremes.
  function automatic logic [31:0] random_price();
    int sel;
    sel = $urandom_range(99);
    if (sel < 35) return $urandom;
    if (sel < 65) return last_price + 32'($urandom_range(0, 2000)) - 32'd1000;
    if (sel < 80) return last_price;
    if (sel < 90) return 32'h0;
    return 32'hFFFF_FFFF;
  endfunction

  task automatic random_phase(input int phase, input int count);
    pick_idling(phase);
    repeat (count) offer_price(random_price());
    drain_unit();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset settings: extremes, flat stretches,
    // a full swing and a ramp, enough to pass the warm-up.
    repeat (4) offer_price(32'h0);
    repeat (4) offer_price(32'hFFFF_FFFF);
    repeat (3) offer_price(32'h5555_5555);
    offer_price(32'hAAAA_AAAA);
    offer_price(32'h0);
    offer_price(32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) offer_price(32'h1000 + 32'(i * 7));
    drain_unit();

    // Smallest windows: every price gives a valid result of zero.
    set_periods(1, 1, 1);
    offer_price(32'h1234);
    offer_price(32'hFFFF_FFFF);
    drain_unit();

    // Zero and oversized periods are clamped; an unused index is ignored.
    set_periods(0, 0, 63);
    write_reg(sho_pkg::REG_UNUSED, 5);
    random_phase(1, 20);
    set_periods(63, 31, 63);
    random_phase(2, 50);

    // Largest legal windows with the full history.
    set_periods(32, 16, 47);
    random_phase(3, 50);

    // History cap below what the windows need: never valid.
    set_periods(5, 4, 7);
    random_phase(0, 20);
    set_periods(3, 2, 0);
    random_phase(1, 15);

    // Back pressure: the receiver holds off while prices keep coming.
    set_periods(4, 3, 20);
    gap_pct = 0;
    stall_pct = 0;
    hold_req = 1;
    repeat (30) offer_price(random_price());
    drain_unit();

    // Random settings, mostly small windows so that items stay quick.
    for (int ph = 0; ph < 8; ph++) begin
      set_periods($urandom_range(1, 10), $urandom_range(1, 5),
                  ($urandom_range(3) == 0) ? $urandom_range(0, 63) : 47);
      random_phase(ph, 60);
    end

    set_periods(2, 1, 47);
    random_phase(3, 20);

    drain_unit();
    repeat (20) @(posedge clk);
    $display("Sent %0d prices over many period settings and idling modes;", items_sent);
    $display("%0d results carried a valid histogram.", valid_seen);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
